FILE: hw/rtl/dopq_pkg.sv
package dopq_pkg;

  localparam int FILL_W    = 5;
  localparam int OUT_LEN_W = 7;
  localparam int DROP_W    = 32;

  localparam logic [7:0] DEPTH_RESET = 8'd16;

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_STATUS  = 2'd3
  } command_t;

  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_REJECTED = 3'd1,
    ST_PKT_BYTE = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_BUSY     = 3'd4,
    ST_REPORT   = 3'd5
  } status_t;

  typedef struct packed {
    command_t   command;
    logic [7:0] data_byte;
    logic [7:0] packet_length;
  } req_t;

  typedef struct packed {
    status_t                status;
    logic [7:0]             out_byte;
    logic [OUT_LEN_W-1:0]   out_length;
    logic                   last_byte;
    logic [FILL_W-1:0]      fill_count;
    logic                   is_full;
    logic [DROP_W-1:0]      drop_total;
  } rsp_t;

endpackage

FILE: hw/rtl/dopq_slot_mem.sv
module dopq_slot_mem #(
  parameter int SLOTS  = 16,
  parameter int BYTES  = 512,
  parameter int SLOT_W = 4,
  parameter int ADDR_W = 9,
  parameter int LEN_W  = 6
) (
  input  logic              clk,
  input  logic              byte_we,
  input  logic [ADDR_W-1:0] byte_waddr,
  input  logic [7:0]        byte_wdata,
  input  logic [ADDR_W-1:0] byte_raddr,
  output logic [7:0]        byte_rdata,
  input  logic              len_we,
  input  logic [SLOT_W-1:0] len_wslot,
  input  logic [LEN_W-1:0]  len_wdata,
  input  logic              len_re,
  input  logic [SLOT_W-1:0] len_rslot,
  output logic [LEN_W-1:0]  len_rdata
);

  logic [7:0]       byte_mem [BYTES];
  logic [LEN_W-1:0] len_mem  [SLOTS];

  always_ff @(posedge clk) begin
    if (byte_we) begin
      byte_mem[byte_waddr] <= byte_wdata;
    end
    byte_rdata <= byte_mem[byte_raddr];
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[len_wslot] <= len_wdata;
    end
    if (len_re) begin
      len_rdata <= len_mem[len_rslot];
    end
  end

endmodule

FILE: hw/rtl/drop_oldest_packet_queue.sv
// Packet queue over a ring of slots that drops the oldest packet when a new
// valid packet starts on a full ring. For enqueue, clear and status commands,
// a command is accepted at an edge with start high and busy low, its single
// result shows on the result port with strobe high in the next cycle, and
// busy stays low so another command can follow at once. A dequeue of a
// stored packet holds busy while its bytes stream: first the registered read
// of the slot length and first byte, then one byte per cycle out of the slot
// byte memory. Results cannot be held off; each one is valid for exactly the
// one cycle strobe is high. Depth writes are taken while busy and start are
// both low, empty the ring and keep the drop count.
module drop_oldest_packet_queue #(
  parameter int MAX_DEPTH   = 16,
  parameter int MAX_PAYLOAD = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  dopq_pkg::req_t request,
  output logic           busy,
  output logic           strobe,
  output dopq_pkg::rsp_t result,
  input  logic           depth_valid,
  output logic           depth_ready,
  input  logic [7:0]     depth_data
);

  localparam int SLOT_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int BYTE_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CNT_W  = $clog2(MAX_DEPTH + 1);
  localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int BYTES  = MAX_DEPTH * MAX_PAYLOAD;
  localparam int ADDR_W = (BYTES > 1) ? $clog2(BYTES) : 1;
  localparam int RST_DEPTH = (int'(dopq_pkg::DEPTH_RESET) > MAX_DEPTH) ?
                             MAX_DEPTH : int'(dopq_pkg::DEPTH_RESET);

  typedef enum logic {
    S_IDLE,
    S_STREAM
  } state_t;

  state_t                       state, state_next;
  logic [SLOT_W-1:0]            head, head_next;
  logic [SLOT_W-1:0]            tail, tail_next;
  logic [CNT_W-1:0]             held, held_next;
  logic [dopq_pkg::DROP_W-1:0]  drops, drops_next;
  logic [LEN_W-1:0]             taken, taken_next;
  logic [LEN_W-1:0]             expected, expected_next;
  logic                         open, open_next;
  logic [LEN_W-1:0]             idx, idx_next;
  logic [CNT_W-1:0]             depth, cfg_depth;
  logic                         strobe_next;
  dopq_pkg::rsp_t               result_next;

  logic                         accept;
  logic                         cfg_write;
  logic                         byte_we;
  logic [ADDR_W-1:0]            byte_waddr;
  logic [ADDR_W-1:0]            byte_raddr;
  logic [7:0]                   byte_rdata;
  logic                         len_we;
  logic                         len_re;
  logic [LEN_W-1:0]             len_rdata;

  logic [CNT_W-1:0]             fill_src;
  logic [CNT_W-1:0]             held_evict;
  logic [LEN_W-1:0]             taken_eff;
  logic [LEN_W-1:0]             exp_eff;
  logic [LEN_W-1:0]             taken_inc;
  logic [BYTE_W-1:0]            rd_byte_idx;
  logic                         bad_len;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s,
                                                  input logic [CNT_W-1:0]  d);
    logic [CNT_W-1:0] s_inc;
    s_inc = CNT_W'(s) + CNT_W'(1);
    return (s_inc == d) ? '0 : SLOT_W'(s_inc);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] s,
                                                  input logic [BYTE_W-1:0] b);
    return ADDR_W'(ADDR_W'(s) * ADDR_W'(MAX_PAYLOAD)) + ADDR_W'(b);
  endfunction

  assign busy        = (state != S_IDLE);
  assign depth_ready = !busy && !start;
  assign accept      = start && !busy;
  assign cfg_write   = depth_valid && depth_ready;

  always_comb begin
    if (depth_data == 8'd0) begin
      cfg_depth = CNT_W'(1);
    end else if (depth_data > 8'(MAX_DEPTH)) begin
      cfg_depth = CNT_W'(MAX_DEPTH);
    end else begin
      cfg_depth = CNT_W'(depth_data);
    end
  end

  always_comb begin
    state_next    = state;
    head_next     = head;
    tail_next     = tail;
    held_next     = held;
    drops_next    = drops;
    taken_next    = taken;
    expected_next = expected;
    open_next     = open;
    idx_next      = idx;
    strobe_next   = 1'b0;
    byte_we       = 1'b0;
    len_we        = 1'b0;
    len_re        = 1'b0;
    rd_byte_idx   = '0;
    held_evict    = held;
    taken_eff     = taken;
    exp_eff       = expected;
    taken_inc     = '0;
    bad_len       = (request.packet_length == 8'd0) ||
                    (request.packet_length > 8'(MAX_PAYLOAD));
    fill_src      = '0;
    result_next   = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          strobe_next = 1'b1;
          unique case (request.command)
            dopq_pkg::CMD_ENQUEUE: begin
              if (!open && bad_len) begin
                result_next.status = dopq_pkg::ST_REJECTED;
              end else begin
                result_next.status = dopq_pkg::ST_STORED;
                if (!open) begin
                  if (held >= depth) begin
                    head_next  = next_slot(head, depth);
                    held_evict = held - CNT_W'(1);
                    drops_next = drops + dopq_pkg::DROP_W'(1);
                  end
                  taken_eff = '0;
                  exp_eff   = LEN_W'(request.packet_length);
                end
                byte_we   = 1'b1;
                taken_inc = taken_eff + LEN_W'(1);
                held_next = held_evict;
                if (taken_inc >= exp_eff) begin
                  len_we        = 1'b1;
                  tail_next     = next_slot(tail, depth);
                  held_next     = held_evict + CNT_W'(1);
                  open_next     = 1'b0;
                  taken_next    = '0;
                  expected_next = '0;
                end else begin
                  open_next     = 1'b1;
                  taken_next    = taken_inc;
                  expected_next = exp_eff;
                end
              end
            end
            dopq_pkg::CMD_DEQUEUE: begin
              result_next.last_byte = 1'b1;
              if (open) begin
                result_next.status = dopq_pkg::ST_BUSY;
              end else if (held == '0) begin
                result_next.status = dopq_pkg::ST_EMPTY;
              end else begin
                strobe_next = 1'b0;
                len_re      = 1'b1;
                idx_next    = '0;
                state_next  = S_STREAM;
              end
            end
            dopq_pkg::CMD_CLEAR: begin
              result_next.status = dopq_pkg::ST_REPORT;
              head_next     = '0;
              tail_next     = '0;
              held_next     = '0;
              taken_next    = '0;
              expected_next = '0;
              open_next     = 1'b0;
            end
            default: begin
              result_next.status = dopq_pkg::ST_REPORT;
            end
          endcase
        end
        fill_src = held_next;
      end
      S_STREAM: begin
        strobe_next            = 1'b1;
        result_next.status     = dopq_pkg::ST_PKT_BYTE;
        result_next.out_byte   = byte_rdata;
        result_next.out_length = dopq_pkg::OUT_LEN_W'(len_rdata);
        rd_byte_idx            = BYTE_W'(idx + LEN_W'(1));
        if (idx + LEN_W'(1) == len_rdata) begin
          result_next.last_byte = 1'b1;
          head_next  = next_slot(head, depth);
          held_next  = held - CNT_W'(1);
          idx_next   = '0;
          state_next = S_IDLE;
        end else begin
          idx_next = idx + LEN_W'(1);
        end
        fill_src = held - CNT_W'(1);
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    result_next.fill_count = dopq_pkg::FILL_W'(fill_src);
    result_next.is_full    = (fill_src >= depth);
    result_next.drop_total = drops_next;
  end

  assign byte_waddr = slot_addr(tail, BYTE_W'(taken_eff));
  assign byte_raddr = slot_addr(head, rd_byte_idx);

  dopq_slot_mem #(
    .SLOTS  (MAX_DEPTH),
    .BYTES  (BYTES),
    .SLOT_W (SLOT_W),
    .ADDR_W (ADDR_W),
    .LEN_W  (LEN_W)
  ) u_slot_mem (
    .clk        (clk),
    .byte_we    (byte_we),
    .byte_waddr (byte_waddr),
    .byte_wdata (request.data_byte),
    .byte_raddr (byte_raddr),
    .byte_rdata (byte_rdata),
    .len_we     (len_we),
    .len_wslot  (tail),
    .len_wdata  (exp_eff),
    .len_re     (len_re),
    .len_rslot  (head),
    .len_rdata  (len_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      tail     <= '0;
      held     <= '0;
      drops    <= '0;
      taken    <= '0;
      expected <= '0;
      open     <= 1'b0;
      idx      <= '0;
      depth    <= CNT_W'(RST_DEPTH);
      strobe   <= 1'b0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      tail     <= tail_next;
      held     <= held_next;
      drops    <= drops_next;
      taken    <= taken_next;
      expected <= expected_next;
      open     <= open_next;
      idx      <= idx_next;
      strobe   <= strobe_next;
      // depth write: empty the ring, keep the drop count
      if (cfg_write) begin
        depth    <= cfg_depth;
        head     <= '0;
        tail     <= '0;
        held     <= '0;
        taken    <= '0;
        expected <= '0;
        open     <= 1'b0;
      end
    end
    result <= result_next;
  end

`ifndef SYNTHESIS
  a_held_within_depth: assert property (@(posedge clk) disable iff (rst)
    held <= depth)
    else $error("held packet count exceeds depth");

  a_open_partial: assert property (@(posedge clk) disable iff (rst)
    open |-> (taken < expected) && (taken != '0))
    else $error("open packet with inconsistent byte count");

  a_stream_emits: assert property (@(posedge clk) disable iff (rst)
    (state == S_STREAM) |=> strobe && (result.status == dopq_pkg::ST_PKT_BYTE))
    else $error("stream cycle without packet byte result");

  a_stream_needs_packet: assert property (@(posedge clk) disable iff (rst)
    (state == S_STREAM) |-> (held != '0) && !open)
    else $error("stream without a stored packet");
`endif

endmodule
